### design/arfs_pkg.sv
// Package for the aged reward flow scheduler.
// Holds sizes, mode and status codes, and the divider request and response types.
// No dependencies.
package arfs_pkg;

  localparam int MAX_FLOWS = 64;
  localparam int FLOW_AW   = 6;
  localparam int CNT_W     = 7;
  localparam int REWARD_W  = 40;
  localparam int SERVICE_W = 48;
  localparam int WEIGHT_W  = 63;
  localparam int DIVD_W    = 48;
  localparam int DIVS_W    = 49;

  typedef enum logic [2:0] {
    MODE_CLEAR      = 3'd0,
    MODE_ADD        = 3'd1,
    MODE_REMOVE     = 3'd2,
    MODE_SET_RUN    = 3'd3,
    MODE_CREDIT     = 3'd4,
    MODE_AGE        = 3'd5,
    MODE_BEST       = 3'd6,
    MODE_BEST_OTHER = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_FULL        = 3'd1,
    ST_BAD_INDEX   = 3'd2,
    ST_ZERO_CREDIT = 3'd3,
    ST_NOT_RUNNING = 3'd4
  } status_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quo;
    logic [DIVS_W-1:0] rem;
  } div_rsp_t;

endpackage

### design/arfs_if.sv
// Handshake interfaces for the input items and the result items.
// Depends on arfs_pkg for field widths.
interface arfs_item_if;
  import arfs_pkg::*;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [6:0]  flow_index;
  logic [23:0] credit_amount;
  logic [31:0] elapsed_us;
  modport source (output valid, mode, flow_index, credit_amount, elapsed_us, input ready);
  modport sink (input valid, mode, flow_index, credit_amount, elapsed_us, output ready);
endinterface

interface arfs_result_if;
  import arfs_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [FLOW_AW-1:0]         chosen_index;
  logic                       found;
  logic signed [WEIGHT_W-1:0] best_weight;
  logic [CNT_W-1:0]           flow_total;
  logic [31:0]                generation;
  logic                       yield_request;
  logic [2:0]                 status;
  modport source (output valid, chosen_index, found, best_weight, flow_total, generation,
                  yield_request, status, input ready);
  modport sink (input valid, chosen_index, found, best_weight, flow_total, generation,
                yield_request, status, output ready);
endinterface

### design/arfs_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on arfs_pkg for the request and response types.
module arfs_divider
  import arfs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r;
  logic [5:0]        cnt_r;
  logic [DIVS_W-1:0] rem_r;
  logic [DIVD_W-1:0] quo_r;
  logic [DIVS_W-1:0] d_r;
  logic              done_r;
  logic [DIVS_W:0]   trial;
  logic              take;

  assign trial = {rem_r, quo_r[DIVD_W-1]};
  assign take  = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= req.dividend;
        d_r    <= req.divisor;
      end else if (busy_r) begin
        rem_r <= take ? DIVS_W'(trial - {1'b0, d_r}) : trial[DIVS_W-1:0];
        quo_r <= {quo_r[DIVD_W-2:0], take};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(DIVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

### design/aged_reward_flow_scheduler_core.sv
// Top level of the aged reward flow scheduler: flow tables, sequencer and APB registers.
// Depends on arfs_pkg, the interfaces in arfs_if and arfs_divider.
// Table edits and flag updates give their result from S_IDLE, or after S_READ and S_EXEC.
// A pick visits each flow once (MODE_BEST_OTHER skips the named flow): two passes through the
// shared radix-2 divider (service over quantum, then 65536 over one plus the rounded-up notch
// count) and a shift-add multiply for the aging term. The block takes a new item only once the
// previous result has been taken.
module aged_reward_flow_scheduler_core
  import arfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  arfs_item_if.sink   in_ch,
  arfs_result_if.source out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_EXEC, S_PNEXT, S_PD1S, S_PD1W, S_PD2S, S_PD2W, S_PMUL, S_PCMP
  } state_t;

  state_t state_r;
  logic [2:0]  op_r;
  logic [CNT_W-1:0] idx_r, count_r, run_r, scan_r;
  logic [23:0] credit_r;
  logic [31:0] elapsed_r, gen_r, quant_r, aging_r;
  logic [FLOW_AW-1:0] addr_r;
  logic [REWARD_W-1:0]  rew_rd_r;
  logic [SERVICE_W-1:0] svc_rd_r;
  logic [REWARD_W-1:0]  rew_mem [MAX_FLOWS];
  logic [SERVICE_W-1:0] svc_mem [MAX_FLOWS];
  logic [DIVD_W-1:0] notch_dn_r;
  logic [DIVS_W-1:0] div2_r;
  logic [16:0] q2_r;
  logic [79:0] acc_r;
  logic [4:0]  mcnt_r;
  logic        found_r;
  logic [FLOW_AW-1:0] chosen_r;
  logic signed [WEIGHT_W-1:0] best_r;

  logic out_valid_r, o_found_r, o_yield_r;
  logic [FLOW_AW-1:0] o_chosen_r;
  logic signed [WEIGHT_W-1:0] o_weight_r;
  logic [CNT_W-1:0] o_total_r;
  logic [31:0] o_gen_r;
  logic [2:0]  o_status_r;

  div_req_t div_req;
  div_rsp_t div_rsp;
  logic accept, cfg_wr;
  logic [31:0] qeff;
  logic rew_we, svc_we;
  logic [FLOW_AW-1:0] waddr;
  logic [REWARD_W-1:0] rew_wd;
  logic [SERVICE_W-1:0] svc_wd;
  logic [REWARD_W:0] rew_sum;
  logic [SERVICE_W:0] svc_sum;
  logic [CNT_W-1:0] last;
  logic [REWARD_W:0] pos;
  logic [63:0] aging64, dneg;
  logic aging_sat;
  logic signed [WEIGHT_W-1:0] w;

  arfs_divider u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  assign accept     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && !out_valid_r;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? aging_r : quant_r;
  assign qeff       = (quant_r == 32'd0) ? 32'd1 : quant_r;
  assign last       = count_r - 7'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quant_r <= 32'd10000;
      aging_r <= 32'd655;
    end else if (cfg_wr) begin
      if (cfg_paddr[2]) aging_r <= cfg_pwdata;
      else quant_r <= cfg_pwdata;
    end
  end

  always_comb begin
    div_req.start    = (state_r == S_PD1S) || (state_r == S_PD2S);
    div_req.dividend = (state_r == S_PD1S) ? svc_rd_r : DIVD_W'(65536);
    div_req.divisor  = (state_r == S_PD1S) ? {17'd0, qeff} : div2_r;
  end

  assign rew_sum = {1'b0, rew_rd_r} + {17'd0, credit_r};
  assign svc_sum = {1'b0, svc_rd_r} + {17'd0, elapsed_r};

  always_comb begin
    rew_we = 1'b0;
    svc_we = 1'b0;
    waddr  = addr_r;
    rew_wd = '0;
    svc_wd = '0;
    if (accept && mode_t'(in_ch.mode) == MODE_ADD && count_r < CNT_W'(MAX_FLOWS)) begin
      rew_we = 1'b1;
      svc_we = 1'b1;
      waddr  = count_r[FLOW_AW-1:0];
    end else if (state_r == S_EXEC) begin
      unique case (mode_t'(op_r))
        MODE_REMOVE: begin
          rew_we = 1'b1;
          svc_we = 1'b1;
          waddr  = idx_r[FLOW_AW-1:0];
          rew_wd = rew_rd_r;
          svc_wd = svc_rd_r;
        end
        MODE_CREDIT: begin
          rew_we = 1'b1;
          svc_we = 1'b1;
          rew_wd = rew_sum[REWARD_W] ? '1 : rew_sum[REWARD_W-1:0];
        end
        MODE_AGE: begin
          svc_we = 1'b1;
          svc_wd = svc_sum[SERVICE_W] ? '1 : svc_sum[SERVICE_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rew_we) rew_mem[waddr] <= rew_wd;
    if (svc_we) svc_mem[waddr] <= svc_wd;
    rew_rd_r <= rew_mem[addr_r];
    svc_rd_r <= svc_mem[addr_r];
  end

  always_comb begin
    pos       = {1'b0, rew_rd_r} + {24'd0, q2_r};
    aging_sat = (|acc_r[79:64]) || (acc_r[63] && (|acc_r[62:0]));
    aging64   = aging_sat ? {1'b1, 63'd0} : acc_r[63:0];
    dneg      = aging64 - {23'd0, pos};
    if (aging64 <= {23'd0, pos}) w = {22'd0, pos - aging64[REWARD_W:0]};
    else if (dneg >= {2'b01, 62'd0}) w = {1'b1, 62'd0};
    else w = -$signed(dneg[WEIGHT_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      run_r       <= CNT_W'(MAX_FLOWS);
      gen_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r       <= in_ch.mode;
            idx_r      <= in_ch.flow_index;
            credit_r   <= in_ch.credit_amount;
            elapsed_r  <= in_ch.elapsed_us;
            o_chosen_r <= '0;
            o_found_r  <= 1'b0;
            o_weight_r <= '0;
            o_yield_r  <= 1'b0;
            o_status_r <= ST_OK;
            o_total_r  <= count_r;
            o_gen_r    <= gen_r;
            unique case (mode_t'(in_ch.mode))
              MODE_CLEAR: begin
                count_r     <= '0;
                run_r       <= CNT_W'(MAX_FLOWS);
                gen_r       <= '0;
                o_total_r   <= '0;
                o_gen_r     <= '0;
                out_valid_r <= 1'b1;
              end
              MODE_ADD: begin
                if (count_r >= CNT_W'(MAX_FLOWS)) begin
                  o_status_r <= ST_FULL;
                end else begin
                  o_chosen_r <= count_r[FLOW_AW-1:0];
                  o_found_r  <= 1'b1;
                  o_yield_r  <= 1'b1;
                  count_r    <= count_r + 7'd1;
                  o_total_r  <= count_r + 7'd1;
                  gen_r      <= gen_r + 32'd1;
                  o_gen_r    <= gen_r + 32'd1;
                end
                out_valid_r <= 1'b1;
              end
              MODE_REMOVE: begin
                if (in_ch.flow_index >= count_r) begin
                  o_status_r  <= ST_BAD_INDEX;
                  out_valid_r <= 1'b1;
                end else begin
                  addr_r  <= last[FLOW_AW-1:0];
                  state_r <= S_READ;
                end
              end
              MODE_SET_RUN: begin
                if (in_ch.flow_index == CNT_W'(MAX_FLOWS)) run_r <= CNT_W'(MAX_FLOWS);
                else if (in_ch.flow_index < count_r) run_r <= in_ch.flow_index;
                else o_status_r <= ST_BAD_INDEX;
                out_valid_r <= 1'b1;
              end
              MODE_CREDIT: begin
                if (in_ch.credit_amount == 24'd0) begin
                  o_status_r  <= ST_ZERO_CREDIT;
                  out_valid_r <= 1'b1;
                end else if (run_r < count_r) begin
                  addr_r  <= run_r[FLOW_AW-1:0];
                  state_r <= S_READ;
                end else begin
                  out_valid_r <= 1'b1;
                end
              end
              MODE_AGE: begin
                if (run_r >= count_r) begin
                  o_status_r  <= ST_NOT_RUNNING;
                  out_valid_r <= 1'b1;
                end else begin
                  addr_r  <= run_r[FLOW_AW-1:0];
                  state_r <= S_READ;
                end
              end
              default: begin
                scan_r  <= '0;
                found_r <= 1'b0;
                state_r <= S_PNEXT;
              end
            endcase
          end
        end
        S_READ: begin
          if (mode_t'(op_r) == MODE_BEST || mode_t'(op_r) == MODE_BEST_OTHER) state_r <= S_PD1S;
          else state_r <= S_EXEC;
        end
        S_EXEC: begin
          if (mode_t'(op_r) == MODE_REMOVE) begin
            if (run_r == idx_r) run_r <= CNT_W'(MAX_FLOWS);
            else if (run_r == last) run_r <= idx_r;
            count_r   <= last;
            o_total_r <= last;
          end
          if (mode_t'(op_r) != MODE_AGE) begin
            gen_r     <= gen_r + 32'd1;
            o_gen_r   <= gen_r + 32'd1;
            o_yield_r <= 1'b1;
          end
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        S_PNEXT: begin
          if (scan_r >= count_r) begin
            o_chosen_r  <= found_r ? chosen_r : '0;
            o_found_r   <= found_r;
            o_weight_r  <= found_r ? best_r : '0;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else if (mode_t'(op_r) == MODE_BEST_OTHER && scan_r == idx_r) begin
            scan_r <= scan_r + 7'd1;
          end else begin
            addr_r  <= scan_r[FLOW_AW-1:0];
            state_r <= S_READ;
          end
        end
        S_PD1S: state_r <= S_PD1W;
        S_PD1W: begin
          if (div_rsp.done) begin
            notch_dn_r <= div_rsp.quo;
            div2_r     <= {1'b0, div_rsp.quo} + DIVS_W'(div_rsp.rem != '0) + DIVS_W'(1);
            state_r    <= S_PD2S;
          end
        end
        S_PD2S: state_r <= S_PD2W;
        S_PD2W: begin
          if (div_rsp.done) begin
            q2_r    <= div_rsp.quo[16:0];
            acc_r   <= '0;
            mcnt_r  <= 5'd31;
            state_r <= S_PMUL;
          end
        end
        S_PMUL: begin
          acc_r <= {acc_r[78:0], 1'b0} + (aging_r[mcnt_r] ? {32'd0, notch_dn_r} : 80'd0);
          if (mcnt_r == 5'd0) state_r <= S_PCMP;
          else mcnt_r <= mcnt_r - 5'd1;
        end
        S_PCMP: begin
          if (!found_r || w > best_r) begin
            found_r  <= 1'b1;
            chosen_r <= scan_r[FLOW_AW-1:0];
            best_r   <= w;
          end
          scan_r  <= scan_r + 7'd1;
          state_r <= S_PNEXT;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.chosen_index  = o_chosen_r;
  assign out_ch.found         = o_found_r;
  assign out_ch.best_weight   = o_weight_r;
  assign out_ch.flow_total    = o_total_r;
  assign out_ch.generation    = o_gen_r;
  assign out_ch.yield_request = o_yield_r;
  assign out_ch.status        = o_status_r;

endmodule

### tb/tb_aged_reward_flow_scheduler_core.sv
// Self-checking testbench for the aged reward flow scheduler core.
// Drives table edits, credit, aging and picks through the item channel and checks each result
// against an in-bench scheduler model. Depends on arfs_pkg, arfs_if.sv and the core RTL.
`timescale 1ns / 100ps

module tb_aged_reward_flow_scheduler_core;
  import arfs_pkg::*;

  localparam logic [2:0] REG_QUANTUM = 3'd0;
  localparam logic [2:0] REG_AGING   = 3'd4;
  localparam longint CYCLE_LIMIT = 64'd6000000;

  typedef struct packed {
    logic [2:0]  mode;
    logic [6:0]  flow_index;
    logic [23:0] credit_amount;
    logic [31:0] elapsed_us;
  } sched_cmd_t;

  typedef struct packed {
    logic [5:0]          chosen_index;
    logic                found;
    logic signed [62:0]  best_weight;
    logic [6:0]          flow_total;
    logic [31:0]         generation;
    logic                yield_request;
    logic [2:0]          status;
  } sched_res_t;

  typedef struct {
    sched_cmd_t cmd;
    bit         typed_in;
    sched_res_t res;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  arfs_item_if   in_ch();
  arfs_result_if out_ch();

  aged_reward_flow_scheduler_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Scheduler shadow state.
  logic [39:0] shadow_reward [MAX_FLOWS];
  logic [47:0] shadow_service [MAX_FLOWS];
  int unsigned shadow_count, shadow_running;
  logic [31:0] shadow_gen, shadow_quantum, shadow_aging;

  sched_res_t pending_results[$];
  int unsigned error_count = 0, items_sent = 0, results_seen = 0, picks_found = 0;
  longint cycle_count = 0;

  function automatic logic signed [62:0] shadow_rank(int unsigned i);
    logic [63:0] q, cpu, up, dn, pos, aging, d;
    q = (shadow_quantum == 0) ? 64'd1 : {32'd0, shadow_quantum};
    cpu = {16'd0, shadow_service[i]};
    up = (cpu + q - 1) / q;
    dn = cpu / q;
    pos = {24'd0, shadow_reward[i]} + 64'd65536 / (64'd1 + up);
    if (shadow_aging != 0 && dn > (64'd1 << 63) / shadow_aging) aging = 64'd1 << 63;
    else aging = dn * shadow_aging;
    if (aging <= pos) begin
      d = pos - aging;
      return (d > 64'h3FFF_FFFF_FFFF_FFFF) ? 63'h3FFF_FFFF_FFFF_FFFF : d[62:0];
    end
    d = aging - pos;
    if (d >= (64'd1 << 62)) return 63'h4000_0000_0000_0000;
    return -$signed({1'b0, d[61:0]});
  endfunction

  function automatic sched_res_t apply_command(sched_cmd_t c);
    sched_res_t r;
    logic signed [62:0] w;
    logic [47:0] sum48;
    logic [40:0] sum41;
    int unsigned last;
    r = '0;
    case (mode_t'(c.mode))
      MODE_CLEAR: begin
        shadow_count = 0; shadow_running = MAX_FLOWS; shadow_gen = 0;
      end
      MODE_ADD: begin
        if (shadow_count >= MAX_FLOWS) r.status = ST_FULL;
        else begin
          r.chosen_index = 6'(shadow_count); r.found = 1'b1;
          shadow_reward[shadow_count] = '0; shadow_service[shadow_count] = '0;
          shadow_count++; shadow_gen++; r.yield_request = 1'b1;
        end
      end
      MODE_REMOVE: begin
        if (c.flow_index >= shadow_count) r.status = ST_BAD_INDEX;
        else begin
          last = shadow_count - 1;
          shadow_reward[c.flow_index] = shadow_reward[last];
          shadow_service[c.flow_index] = shadow_service[last];
          if (shadow_running == c.flow_index) shadow_running = MAX_FLOWS;
          else if (shadow_running == last) shadow_running = c.flow_index;
          shadow_count = last; shadow_gen++; r.yield_request = 1'b1;
        end
      end
      MODE_SET_RUN: begin
        if (c.flow_index == MAX_FLOWS) shadow_running = MAX_FLOWS;
        else if (c.flow_index < shadow_count) shadow_running = c.flow_index;
        else r.status = ST_BAD_INDEX;
      end
      MODE_CREDIT: begin
        if (c.credit_amount == 0) r.status = ST_ZERO_CREDIT;
        else if (shadow_running < shadow_count) begin
          sum41 = {1'b0, shadow_reward[shadow_running]} + c.credit_amount;
          shadow_reward[shadow_running] = sum41[40] ? '1 : sum41[39:0];
          shadow_service[shadow_running] = '0;
          shadow_gen++; r.yield_request = 1'b1;
        end
      end
      MODE_AGE: begin
        if (shadow_running >= shadow_count) r.status = ST_NOT_RUNNING;
        else begin
          sum48 = shadow_service[shadow_running] + c.elapsed_us;
          shadow_service[shadow_running] =
            (sum48 < shadow_service[shadow_running]) ? '1 : sum48;
        end
      end
      default: begin
        for (int unsigned i = 0; i < shadow_count; i++) begin
          if (c.mode == MODE_BEST_OTHER && i == c.flow_index) continue;
          w = shadow_rank(i);
          if (!r.found || w > r.best_weight) begin
            r.found = 1'b1; r.chosen_index = 6'(i); r.best_weight = w;
          end
        end
      end
    endcase
    r.flow_total = 7'(shadow_count);
    r.generation = shadow_gen;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    error_count++;
    $display("mismatch on result %0d: %s got %0h expected %0h", results_seen, what, got, want);
  endtask

  task automatic write_register(logic [2:0] addr, logic [31:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= addr; cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    if (addr == REG_QUANTUM) shadow_quantum = value;
    else shadow_aging = value;
  endtask

  task automatic send_command(sched_cmd_t c);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= c.mode; in_ch.flow_index <= c.flow_index;
    in_ch.credit_amount <= c.credit_amount; in_ch.elapsed_us <= c.elapsed_us;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(apply_command(c));
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic sched_cmd_t random_command(int unsigned depth_bias);
    sched_cmd_t c;
    int unsigned pick;
    c.credit_amount = ($urandom_range(0, 9) == 0) ? 24'd0 :
                      ($urandom_range(0, 4) == 0) ? 24'hFFFFFF : 24'($urandom);
    c.elapsed_us = ($urandom_range(0, 7) == 0) ? 32'hFFFFFFFF : $urandom_range(0, 60000);
    if ($urandom_range(0, 15) == 0) c.elapsed_us = $urandom;
    c.flow_index = (shadow_count != 0 && $urandom_range(0, 5) != 0) ?
                   7'($urandom_range(0, shadow_count - 1)) : 7'($urandom_range(0, 127));
    pick = $urandom_range(0, 99);
    if (pick < 2) c.mode = MODE_CLEAR;
    else if (pick < 12 + depth_bias) c.mode = MODE_ADD;
    else if (pick < 20 + depth_bias) c.mode = MODE_REMOVE;
    else if (pick < 34 + depth_bias) c.mode = MODE_SET_RUN;
    else if (pick < 50 + depth_bias) c.mode = MODE_CREDIT;
    else if (pick < 70 + depth_bias) c.mode = MODE_AGE;
    else if (pick < 85) c.mode = MODE_BEST;
    else c.mode = MODE_BEST_OTHER;
    return c;
  endfunction

  // Result side: random stalls, sampled at the rising edge.
  initial begin
    int stall;
    sched_res_t got, want;
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got = '{out_ch.chosen_index, out_ch.found, out_ch.best_weight, out_ch.flow_total,
              out_ch.generation, out_ch.yield_request, out_ch.status};
      results_seen++;
      if (pending_results.size() == 0) begin
        error_count++;
        $display("unexpected result %0d with no item outstanding", results_seen);
      end else begin
        want = pending_results.pop_front();
        if (got.found && got.status == ST_OK && want.found && !want.yield_request) picks_found++;
        if (got.chosen_index !== want.chosen_index)
          report_mismatch("chosen_index", got.chosen_index, want.chosen_index);
        if (got.found !== want.found) report_mismatch("found", got.found, want.found);
        if (got.best_weight !== want.best_weight)
          report_mismatch("best_weight", got.best_weight, want.best_weight);
        if (got.flow_total !== want.flow_total)
          report_mismatch("flow_total", got.flow_total, want.flow_total);
        if (got.generation !== want.generation)
          report_mismatch("generation", got.generation, want.generation);
        if (got.yield_request !== want.yield_request)
          report_mismatch("yield_request", got.yield_request, want.yield_request);
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
      end
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    directed_row_t rows[$];
    directed_row_t row;
    sched_res_t want;
    in_ch.valid = 1'b0; in_ch.mode = '0; in_ch.flow_index = '0;
    in_ch.credit_amount = '0; in_ch.elapsed_us = '0;
    shadow_count = 0; shadow_running = MAX_FLOWS; shadow_gen = 0;
    shadow_quantum = 32'd10000; shadow_aging = 32'd655;
    for (int i = 0; i < MAX_FLOWS; i++) begin
      shadow_reward[i] = '0; shadow_service[i] = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table: checks typed in where obvious, the rest by the model.
    rows = '{
      '{'{MODE_BEST, 7'd0, 24'd0, 32'd0}, 1'b1, '{6'd0, 1'b0, '0, 7'd0, 32'd0, 1'b0, ST_OK}},
      '{'{MODE_AGE, 7'd0, 24'd5, 32'd5}, 1'b1,
        '{6'd0, 1'b0, '0, 7'd0, 32'd0, 1'b0, ST_NOT_RUNNING}},
      '{'{MODE_CREDIT, 7'd0, 24'd0, 32'd0}, 1'b1,
        '{6'd0, 1'b0, '0, 7'd0, 32'd0, 1'b0, ST_ZERO_CREDIT}},
      '{'{MODE_CREDIT, 7'd0, 24'd7, 32'd0}, 1'b1, '{6'd0, 1'b0, '0, 7'd0, 32'd0, 1'b0, ST_OK}},
      '{'{MODE_REMOVE, 7'd0, 24'd0, 32'd0}, 1'b1,
        '{6'd0, 1'b0, '0, 7'd0, 32'd0, 1'b0, ST_BAD_INDEX}},
      '{'{MODE_ADD, 7'd127, 24'hFFFFFF, 32'hFFFFFFFF}, 1'b1,
        '{6'd0, 1'b1, '0, 7'd1, 32'd1, 1'b1, ST_OK}},
      '{'{MODE_ADD, 7'd0, 24'd0, 32'd0}, 1'b0, '0},
      '{'{MODE_ADD, 7'd0, 24'd0, 32'd0}, 1'b0, '0},
      '{'{MODE_SET_RUN, 7'd127, 24'd0, 32'd0}, 1'b0, '0},
      '{'{MODE_SET_RUN, 7'd2, 24'd0, 32'd0}, 1'b0, '0},
      '{'{MODE_CREDIT, 7'd0, 24'hFFFFFF, 32'd0}, 1'b0, '0},
      '{'{MODE_AGE, 7'd0, 24'd0, 32'hFFFFFFFF}, 1'b0, '0},
      '{'{MODE_AGE, 7'd0, 24'd0, 32'd12345}, 1'b0, '0},
      '{'{MODE_BEST, 7'd0, 24'd0, 32'd0}, 1'b0, '0},
      '{'{MODE_BEST_OTHER, 7'd2, 24'd0, 32'd0}, 1'b0, '0},
      '{'{MODE_BEST_OTHER, 7'd64, 24'd0, 32'd0}, 1'b0, '0},
      '{'{MODE_SET_RUN, 7'd64, 24'd0, 32'd0}, 1'b0, '0},
      '{'{MODE_AGE, 7'd0, 24'd0, 32'd1}, 1'b0, '0},
      '{'{MODE_SET_RUN, 7'd1, 24'd0, 32'd0}, 1'b0, '0},
      '{'{MODE_REMOVE, 7'd1, 24'd0, 32'd0}, 1'b0, '0},
      '{'{MODE_SET_RUN, 7'd1, 24'd0, 32'd0}, 1'b0, '0},
      '{'{MODE_REMOVE, 7'd0, 24'd0, 32'd0}, 1'b0, '0},
      '{'{MODE_BEST, 7'd0, 24'd0, 32'd0}, 1'b0, '0},
      '{'{MODE_CLEAR, 7'd0, 24'd0, 32'd0}, 1'b1, '{6'd0, 1'b0, '0, 7'd0, 32'd0, 1'b0, ST_OK}}
    };
    foreach (rows[k]) begin
      row = rows[k];
      send_command(row.cmd);
      if (row.typed_in) begin
        want = pending_results[$];
        if (want !== row.res) begin
          error_count++;
          $display("directed row %0d disagrees with the scheduler model", k);
        end
        pending_results[$] = row.res;
      end
    end
    wait_idle();

    // Fill the table to the limit, then hit the full case once.
    for (int i = 0; i <= MAX_FLOWS; i++) send_command('{MODE_ADD, 7'd0, 24'd0, 32'd0});
    send_command('{MODE_SET_RUN, 7'd63, 24'd0, 32'd0});
    send_command('{MODE_CREDIT, 7'd0, 24'd1, 32'd0});
    send_command('{MODE_BEST, 7'd0, 24'd0, 32'd0});
    send_command('{MODE_REMOVE, 7'd5, 24'd0, 32'd0});
    send_command('{MODE_CLEAR, 7'd0, 24'd0, 32'd0});
    wait_idle();

    // Random phases through several register settings, extremes included.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin write_register(REG_QUANTUM, 32'd10000); write_register(REG_AGING, 32'd655); end
        1: begin write_register(REG_QUANTUM, 32'd1); write_register(REG_AGING, 32'hFFFFFFFF); end
        2: begin write_register(REG_QUANTUM, 32'hFFFFFFFF); write_register(REG_AGING, 32'd0); end
        3: begin write_register(REG_QUANTUM, 32'd0); write_register(REG_AGING, 32'd1); end
        default: begin
          write_register(REG_QUANTUM, $urandom_range(1, 50000));
          write_register(REG_AGING, $urandom_range(0, 100000));
        end
      endcase
      for (int n = 0; n < 9; n++) send_command(random_command((n < 3) ? 8 : 0));
      wait_idle();
    end

    $display("Sent %0d items, checked %0d results, %0d of them picks with a winner.",
             items_sent, results_seen, picks_found);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
